// ===== src/rfcp_pkg.sv =====
// Shared types, constants and helper functions for the radar frame to
// Cartesian point converter. No dependencies; imported by every module.
`timescale 1ns / 1ps

package rfcp_pkg;

    // Number of CORDIC cells in each rotation chain (8 to 24).
    localparam int CORDIC_STAGES = 16;
    localparam int ATAN_ENTRIES  = 24;
    localparam int STAGE_IDX_W   = 5;

    // Number of register stages in the angle reduction pipeline.
    localparam int PREP_LAT = 4;

    // Frame acceptance.
    localparam logic [3:0] MIN_FRAME_LEN = 4'd8;

    // Angle folding limits in 0.01 degree.
    localparam logic [15:0] DEG_FULL    = 16'd36000;
    localparam logic [15:0] DEG_HALF    = 16'd18000;
    localparam logic [15:0] DEG_QUARTER = 16'd9000;
    localparam logic [15:0] DEG_3QUART  = 16'd27000;

    // Scaling of a centidegree magnitude m to 2^32 units per turn:
    // round(m * 2^32 / 36000) = m * 119304 + floor((m * 728 + 562) / 1125).
    localparam logic [30:0] TURN_SCALE_HI = 31'd119304;
    localparam logic [22:0] TURN_REM_MUL  = 23'd728;
    localparam logic [22:0] TURN_REM_ADD  = 23'd562;
    // floor(t / 1125) = (t * ceil(2^36 / 1125)) >> 36 for t below 2^23
    localparam logic [48:0] RECIP_1125    = 49'd61083980;
    localparam int          RECIP_SHIFT   = 36;

    // CORDIC start vector magnitude in Q2.30.
    localparam logic signed [31:0] CORDIC_GAIN_Q30 = 32'sd652032874;

    // Rounding offsets.
    localparam logic signed [32:0] ROUND_Q15 = 33'sd16384;
    localparam logic signed [49:0] ROUND_Q30 = 50'sd536870912;

    typedef logic [STAGE_IDX_W-1:0] stage_idx_t;

    // One received CAN frame.
    typedef struct packed {
        logic [28:0] can_id;
        logic [3:0]  frame_len;
        logic [63:0] frame_data;
    } frame_t;

    // One Cartesian point.
    typedef struct packed {
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic signed [15:0] pos_z;
        logic signed [7:0]  echo_power;
    } point_t;

    // Rotation vector and residual angle handed from cell to cell.
    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } cordic_vec_t;

    // Per-frame data that travels beside the CORDIC chains.
    typedef struct packed {
        logic signed [15:0] range;
        logic signed [7:0]  power;
    } side_t;

    // Arctangent of 2^-i in 2^32 units per turn, truncated.
    function automatic logic signed [31:0] atan_unit(input stage_idx_t idx);
        logic signed [31:0] val;
        case (idx)
            5'd0:    val = 32'sd536870912;
            5'd1:    val = 32'sd316933406;
            5'd2:    val = 32'sd167458907;
            5'd3:    val = 32'sd85004756;
            5'd4:    val = 32'sd42667331;
            5'd5:    val = 32'sd21354465;
            5'd6:    val = 32'sd10680094;
            5'd7:    val = 32'sd5340245;
            5'd8:    val = 32'sd2670163;
            5'd9:    val = 32'sd1335087;
            5'd10:   val = 32'sd667544;
            5'd11:   val = 32'sd333772;
            5'd12:   val = 32'sd166886;
            5'd13:   val = 32'sd83443;
            5'd14:   val = 32'sd41721;
            5'd15:   val = 32'sd20860;
            5'd16:   val = 32'sd10430;
            5'd17:   val = 32'sd5215;
            5'd18:   val = 32'sd2607;
            5'd19:   val = 32'sd1303;
            5'd20:   val = 32'sd651;
            5'd21:   val = 32'sd325;
            5'd22:   val = 32'sd162;
            5'd23:   val = 32'sd81;
            default: val = 32'sd0;
        endcase
        return val;
    endfunction

    // Clamp to the signed 16-bit range.
    function automatic logic signed [15:0] sat16(input logic signed [49:0] v);
        logic signed [15:0] res;
        if (v > 50'sd32767) begin
            res = 16'sh7fff;
        end else if (v < -50'sd32768) begin
            res = 16'sh8000;
        end else begin
            res = v[15:0];
        end
        return res;
    endfunction

    // Q2.30 to Q1.15 with round half up and saturation.
    function automatic logic signed [15:0] q15_round(input logic signed [31:0] v);
        logic signed [32:0] sum;
        logic signed [32:0] shifted;
        sum     = 33'(v) + ROUND_Q15;
        shifted = sum >>> 15;
        return sat16(50'(shifted));
    endfunction

endpackage

// ===== src/rfcp_angle_prep.sv =====
// Angle reduction for one angle: modulo one turn, fold to +-90 degrees and
// scale to 2^32 units per turn. Depends on rfcp_pkg.
`timescale 1ns / 1ps

module rfcp_angle_prep (
    input  logic               aclk,
    input  logic               en,
    input  logic signed [15:0] cdeg,
    output logic signed [31:0] z_start,
    output logic               neg_cos
);
    import rfcp_pkg::*;

    logic [15:0]        a_val;
    logic [13:0]        mag_next;
    logic               bneg_next;
    logic               negc_next;
    logic [13:0]        mag_reg;
    logic               bneg1_reg;
    logic               negc1_reg;

    logic [22:0]        rem_next;
    logic [30:0]        hi_next;
    logic [22:0]        rem_reg;
    logic [30:0]        hi2_reg;
    logic               bneg2_reg;
    logic               negc2_reg;

    logic [48:0]        recip_prod;
    logic [12:0]        lo_next;
    logic [12:0]        lo_reg;
    logic [30:0]        hi3_reg;
    logic               bneg3_reg;
    logic               negc3_reg;

    logic [30:0]        zmag;
    logic signed [31:0] z_next;
    logic signed [31:0] z_reg;
    logic               negc4_reg;

    // Reduce modulo one turn and fold into [-90, 90] degrees
    always_comb begin
        a_val = cdeg[15] ? ($unsigned(cdeg) + DEG_FULL) : $unsigned(cdeg);
        if (a_val > DEG_3QUART) begin
            mag_next  = 14'(DEG_FULL - a_val);
            bneg_next = 1'b1;
            negc_next = 1'b0;
        end else if (a_val > DEG_QUARTER) begin
            negc_next = 1'b1;
            if (a_val > DEG_HALF) begin
                mag_next  = 14'(a_val - DEG_HALF);
                bneg_next = 1'b1;
            end else begin
                mag_next  = 14'(DEG_HALF - a_val);
                bneg_next = 1'b0;
            end
        end else begin
            mag_next  = 14'(a_val);
            bneg_next = 1'b0;
            negc_next = 1'b0;
        end
    end

    // Split the scaling into an integer part and a remainder term
    assign rem_next = 23'(23'(mag_reg) * TURN_REM_MUL + TURN_REM_ADD);
    assign hi_next  = 31'(31'(mag_reg) * TURN_SCALE_HI);

    // Divide the remainder term by 1125 through the reciprocal
    assign recip_prod = 49'(rem_reg) * RECIP_1125;
    assign lo_next    = recip_prod[48:RECIP_SHIFT];

    // Combine and apply the sign
    assign zmag   = hi3_reg + 31'(lo_reg);
    assign z_next = bneg3_reg ? -$signed({1'b0, zmag}) : $signed({1'b0, zmag});

    // Advance all stages together
    always_ff @(posedge aclk) begin
        if (en) begin
            mag_reg   <= mag_next;
            bneg1_reg <= bneg_next;
            negc1_reg <= negc_next;

            rem_reg   <= rem_next;
            hi2_reg   <= hi_next;
            bneg2_reg <= bneg1_reg;
            negc2_reg <= negc1_reg;

            lo_reg    <= lo_next;
            hi3_reg   <= hi2_reg;
            bneg3_reg <= bneg2_reg;
            negc3_reg <= negc2_reg;

            z_reg     <= z_next;
            negc4_reg <= negc3_reg;
        end
    end

    assign z_start = z_reg;
    assign neg_cos = negc4_reg;

endmodule

// ===== src/rfcp_cordic_cell.sv =====
// One rotation-mode CORDIC cell: a single micro-rotation, registered.
// Depends on rfcp_pkg for the vector type and the arctangent table.
`timescale 1ns / 1ps

module rfcp_cordic_cell (
    input  logic                     aclk,
    input  logic                     en,
    input  rfcp_pkg::stage_idx_t     stage_idx,
    input  rfcp_pkg::cordic_vec_t    vec_in,
    output rfcp_pkg::cordic_vec_t    vec_out
);
    import rfcp_pkg::*;

    logic signed [31:0] dx;
    logic signed [31:0] dy;
    logic signed [31:0] ang;
    cordic_vec_t        vec_next;
    cordic_vec_t        vec_reg;

    // Rotate toward a zero residual angle
    always_comb begin
        dx  = vec_in.y >>> stage_idx;
        dy  = vec_in.x >>> stage_idx;
        ang = atan_unit(stage_idx);
        if (!vec_in.z[31]) begin
            vec_next.x = vec_in.x - dx;
            vec_next.y = vec_in.y + dy;
            vec_next.z = vec_in.z - ang;
        end else begin
            vec_next.x = vec_in.x + dx;
            vec_next.y = vec_in.y - dy;
            vec_next.z = vec_in.z + ang;
        end
    end

    // Hand the vector to the next cell
    always_ff @(posedge aclk) begin
        if (en) begin
            vec_reg <= vec_next;
        end
    end

    assign vec_out = vec_reg;

endmodule

// ===== src/rfcp_out_buf.sv =====
// Two-entry output buffer between the point pipeline and the result channel.
// Depends on rfcp_pkg for the point type.
`timescale 1ns / 1ps

module rfcp_out_buf (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  rfcp_pkg::point_t push_data,
    output logic             full,
    output logic             m_valid,
    input  logic             m_ready,
    output rfcp_pkg::point_t m_data
);
    import rfcp_pkg::*;

    point_t      entry_reg [2];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  count_reg;
    logic [1:0]  count_next;
    logic        pop;

    assign pop     = m_valid & m_ready;
    assign full    = (count_reg == 2'd2);
    assign m_valid = (count_reg != 2'd0);
    assign m_data  = entry_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    // Track pointers and fill level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
        end
    end

    // Store an incoming point
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== src/radar_frame_to_cartesian_point.sv =====
// Top level of the radar frame to Cartesian point converter: frame filter,
// angle reduction, two CORDIC cell chains, projection and output buffer.
// Depends on rfcp_pkg, rfcp_angle_prep, rfcp_cordic_cell and rfcp_out_buf.
//
//   Channel   Ports                          Direction  Content
//   ------------------------------------------------------------------------
//   frame     s_valid  s_ready  s_data       in         CAN frame (frame_t)
//   point     m_valid  m_ready  m_data       out        point (point_t)
//   config    cfg_valid cfg_ready cfg_data   in         radar identifier
//
// One frame is taken every cycle unless the pipeline stalls; a frame passes
// the input registers, the angle reduction, the CORDIC cells and the sine and
// cosine, product and projection registers before its point is buffered.
// Frames with another identifier or a length code below 8 leave a bubble.
// The pipeline stalls only when both output buffer entries are occupied and
// a point reaches its end; cfg_ready is always high.
// Reset clears the identifier to 0 and empties the pipeline and the buffer.
`timescale 1ns / 1ps

module radar_frame_to_cartesian_point (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  rfcp_pkg::frame_t s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output rfcp_pkg::point_t m_data,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [28:0]      cfg_data
);
    import rfcp_pkg::*;

    localparam int LINE = PREP_LAT + CORDIC_STAGES;

    logic               adv;
    logic               buf_full;
    logic               push;
    point_t             push_data;

    logic [28:0]        cfg_id_reg;

    // Input stage
    logic               frame_match;
    logic               v0_next;
    logic               v0_reg;
    side_t              side0_reg;
    logic signed [15:0] az0_reg;
    logic signed [15:0] el0_reg;

    // Side data line beside angle reduction and CORDIC chains
    logic [LINE-1:0]    v_line_reg;
    side_t              side_line_reg [LINE];
    logic [1:0]         neg_line_reg [CORDIC_STAGES];

    logic signed [31:0] z_az;
    logic signed [31:0] z_el;
    logic               negc_az;
    logic               negc_el;

    cordic_vec_t        az_vec [CORDIC_STAGES+1];
    cordic_vec_t        el_vec [CORDIC_STAGES+1];

    // Sine and cosine stage
    logic signed [15:0] cos_az_raw;
    logic signed [15:0] cos_el_raw;
    logic               sc_v_reg;
    logic signed [15:0] sa_reg;
    logic signed [16:0] ca_reg;
    logic signed [15:0] se_reg;
    logic signed [16:0] ce_reg;
    side_t              sc_side_reg;

    // First product stage
    logic               m1_v_reg;
    logic signed [32:0] rc_reg;
    logic signed [31:0] rse_reg;
    logic signed [15:0] m1_sa_reg;
    logic signed [16:0] m1_ca_reg;
    logic signed [7:0]  m1_pw_reg;

    // Second product stage
    logic signed [32:0] pz_sum;
    logic signed [32:0] pz_shift;
    logic               m2_v_reg;
    logic signed [49:0] px_p_reg;
    logic signed [49:0] py_p_reg;
    logic signed [15:0] pz_reg;
    logic signed [7:0]  m2_pw_reg;

    logic signed [49:0] px_shift;
    logic signed [49:0] py_shift;

    // Stall everything only when a point is ready and the buffer is full
    assign adv       = !buf_full || !m2_v_reg;
    assign s_ready   = adv;
    assign cfg_ready = 1'b1;

    assign frame_match = (s_data.can_id == cfg_id_reg) &&
                         (s_data.frame_len >= MIN_FRAME_LEN);
    assign v0_next     = s_valid & frame_match;

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_id_reg <= '0;
            v0_reg     <= 1'b0;
            v_line_reg <= '0;
            sc_v_reg   <= 1'b0;
            m1_v_reg   <= 1'b0;
            m2_v_reg   <= 1'b0;
        end else begin
            if (cfg_valid) begin
                cfg_id_reg <= cfg_data;
            end
            if (adv) begin
                v0_reg     <= v0_next;
                v_line_reg <= {v_line_reg[LINE-2:0], v0_reg};
                sc_v_reg   <= v_line_reg[LINE-1];
                m1_v_reg   <= sc_v_reg;
                m2_v_reg   <= m1_v_reg;
            end
        end
    end

    // Unpack the frame and shift the side data along
    always_ff @(posedge aclk) begin
        if (adv) begin
            side0_reg.range  <= $signed(s_data.frame_data[23:8]);
            side0_reg.power  <= $signed(s_data.frame_data[63:56]);
            az0_reg          <= $signed(s_data.frame_data[39:24]);
            el0_reg          <= $signed(s_data.frame_data[55:40]);
            side_line_reg[0] <= side0_reg;
            for (int k = 1; k < LINE; k++) begin
                side_line_reg[k] <= side_line_reg[k-1];
            end
            neg_line_reg[0] <= {negc_az, negc_el};
            for (int k = 1; k < CORDIC_STAGES; k++) begin
                neg_line_reg[k] <= neg_line_reg[k-1];
            end
        end
    end

    // Angle reduction for azimuth and elevation
    rfcp_angle_prep u_prep_az (
        .aclk    (aclk),
        .en      (adv),
        .cdeg    (az0_reg),
        .z_start (z_az),
        .neg_cos (negc_az)
    );

    rfcp_angle_prep u_prep_el (
        .aclk    (aclk),
        .en      (adv),
        .cdeg    (el0_reg),
        .z_start (z_el),
        .neg_cos (negc_el)
    );

    assign az_vec[0] = '{x: CORDIC_GAIN_Q30, y: 32'sd0, z: z_az};
    assign el_vec[0] = '{x: CORDIC_GAIN_Q30, y: 32'sd0, z: z_el};

    // Two rows of CORDIC cells
    for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cell
        rfcp_cordic_cell u_cell_az (
            .aclk      (aclk),
            .en        (adv),
            .stage_idx (STAGE_IDX_W'(k)),
            .vec_in    (az_vec[k]),
            .vec_out   (az_vec[k+1])
        );

        rfcp_cordic_cell u_cell_el (
            .aclk      (aclk),
            .en        (adv),
            .stage_idx (STAGE_IDX_W'(k)),
            .vec_in    (el_vec[k]),
            .vec_out   (el_vec[k+1])
        );
    end

    assign cos_az_raw = q15_round(az_vec[CORDIC_STAGES].x);
    assign cos_el_raw = q15_round(el_vec[CORDIC_STAGES].x);

    // Round sine and cosine to Q1.15 and restore the cosine sign
    always_ff @(posedge aclk) begin
        if (adv) begin
            sa_reg      <= q15_round(az_vec[CORDIC_STAGES].y);
            se_reg      <= q15_round(el_vec[CORDIC_STAGES].y);
            ca_reg      <= neg_line_reg[CORDIC_STAGES-1][1] ? -17'(cos_az_raw)
                                                            : 17'(cos_az_raw);
            ce_reg      <= neg_line_reg[CORDIC_STAGES-1][0] ? -17'(cos_el_raw)
                                                            : 17'(cos_el_raw);
            sc_side_reg <= side_line_reg[LINE-1];
        end
    end

    // Scale the range by the elevation terms
    always_ff @(posedge aclk) begin
        if (adv) begin
            rc_reg    <= 33'(sc_side_reg.range) * 33'(ce_reg);
            rse_reg   <= 32'(sc_side_reg.range) * 32'(se_reg);
            m1_sa_reg <= sa_reg;
            m1_ca_reg <= ca_reg;
            m1_pw_reg <= sc_side_reg.power;
        end
    end

    // Vertical coordinate is -r*sin(el) rounded from Q15
    assign pz_sum   = -33'(rse_reg) + ROUND_Q15;
    assign pz_shift = pz_sum >>> 15;

    // Project onto the horizontal axes
    always_ff @(posedge aclk) begin
        if (adv) begin
            px_p_reg  <= 50'(rc_reg) * 50'(m1_sa_reg);
            py_p_reg  <= 50'(rc_reg) * 50'(m1_ca_reg);
            pz_reg    <= sat16(50'(pz_shift));
            m2_pw_reg <= m1_pw_reg;
        end
    end

    // Round the Q30 products and hand the point to the buffer
    assign px_shift = (px_p_reg + ROUND_Q30) >>> 30;
    assign py_shift = (py_p_reg + ROUND_Q30) >>> 30;

    always_comb begin
        push_data.pos_x      = sat16(px_shift);
        push_data.pos_y      = sat16(py_shift);
        push_data.pos_z      = pz_reg;
        push_data.echo_power = m2_pw_reg;
    end

    assign push = adv & m2_v_reg;

    rfcp_out_buf u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .full      (buf_full),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

// ===== src/rfcp_checker.sv =====
// Port-level checks for the radar frame to Cartesian point converter and
// the bind that attaches them. Depends on rfcp_pkg and the top level.
`timescale 1ns / 1ps

module rfcp_checker (
    input logic             aclk,
    input logic             aresetn,
    input logic             s_ready,
    input logic             m_valid,
    input logic             m_ready,
    input rfcp_pkg::point_t m_data
);
    import rfcp_pkg::*;

    // A stalled point holds its value until transferred
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("point changed while stalled");

    // Reset empties the output buffer
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("point valid after reset");

    // Reset leaves the frame channel open
    a_reset_ready: assert property (@(posedge aclk)
        !aresetn |=> s_ready)
        else $error("frame channel closed after reset");

    // Frames are refused only while a point waits at the output
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid)
        else $error("frame channel closed with no point pending");

endmodule

bind radar_frame_to_cartesian_point rfcp_checker u_rfcp_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
